[sv/bpr_pkg.sv]
// Shared types, constants and channel expansion functions for the bitmap pixel converter.
package bpr_pkg;

  localparam int PIXEL_W     = 32;
  localparam int INDEX_W     = 8;
  localparam int COLOR_W     = 24;
  localparam int CHAN_W      = 8;
  localparam int BPP_W       = 6;
  localparam int PAL_COUNT_W = 9;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 9;

  // request types
  localparam logic REQ_CONVERT   = 1'b0;
  localparam logic REQ_PAL_WRITE = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BPP       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BITFIELDS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAL_COUNT = 2'd2;

  // source depths
  localparam logic [BPP_W-1:0] BPP_8  = 6'd8;
  localparam logic [BPP_W-1:0] BPP_16 = 6'd16;
  localparam logic [BPP_W-1:0] BPP_24 = 6'd24;
  localparam logic [BPP_W-1:0] BPP_32 = 6'd32;

  localparam logic [BPP_W-1:0]       BPP_RESET     = BPP_24;
  localparam logic [PAL_COUNT_W-1:0] PAL_COUNT_MAX = 9'd256;
  localparam logic [CHAN_W-1:0]      GREY_LEVEL    = 8'd128;
  localparam logic [CHAN_W-1:0]      ALPHA_OPAQUE  = 8'hFF;

  typedef struct packed {
    logic [BPP_W-1:0]       bpp;
    logic                   bitfields;
    logic [PAL_COUNT_W-1:0] pal_count;
  } cfg_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               pal_hit;
  } conv_req_t;

  // v*255/31 truncated: 8v + floor(7v/31), quotient by shift plus one correction
  function automatic logic [CHAN_W-1:0] expand5(input logic [4:0] v);
    logic [7:0] y;
    logic [2:0] q0;
    logic [5:0] r;
    logic [2:0] q;
    y  = 8'(v) * 8'd7;
    q0 = y[7:5];
    r  = {1'b0, y[4:0]} + 6'(q0);
    q  = (r >= 6'd31) ? q0 + 3'd1 : q0;
    return {v, 3'b000} + 8'(q);
  endfunction

  // v*255/63 truncated: 4v + floor(3v/63)
  function automatic logic [CHAN_W-1:0] expand6(input logic [5:0] v);
    logic [7:0] y;
    logic [1:0] q0;
    logic [6:0] r;
    logic [1:0] q;
    y  = 8'(v) * 8'd3;
    q0 = y[7:6];
    r  = {1'b0, y[5:0]} + 7'(q0);
    q  = (r >= 7'd63) ? q0 + 2'd1 : q0;
    return {v, 2'b00} + 8'(q);
  endfunction

endpackage

[sv/bpr_channels.sv]
// Handshake channel interfaces: pixel requests, RGBA results and configuration writes.
interface bpr_in_if;
  import bpr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic [PIXEL_W-1:0]   raw_pixel;
  logic [INDEX_W-1:0]   palette_index;
  logic [COLOR_W-1:0]   palette_color;
  modport source (output valid, req_type, raw_pixel, palette_index, palette_color,
                  input ready);
  modport sink   (input valid, req_type, raw_pixel, palette_index, palette_color,
                  output ready);
endinterface

interface bpr_out_if;
  import bpr_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  logic [CHAN_W-1:0] alpha;
  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

interface bpr_cfg_if;
  import bpr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[sv/bmp_pixel_to_rgba_converter.sv]
// Top level of the bitmap pixel to RGBA8888 converter.
// Usage:
//   in_chan carries requests. req_type selects a pixel conversion or a palette
//   write (palette_index, palette_color); a palette write yields no result.
//   out_chan returns one RGBA8888 result per conversion, in request order.
//   cfg_chan writes bits_per_pixel (0), bitfields_mode (1) and palette_count (2);
//   it is always ready. The user must write it only while no request is in flight; not enforced.
// Timing:
//   An accepted conversion passes the read stage, then the result register.
//   One request per cycle is sustained while out_chan.ready is high; the palette
//   memory read issued at acceptance is registered and feeds the expansion stage.
//   A palette write lands in memory at its acceptance edge, so a conversion in
//   the next cycle already reads the new word.
// Reset:
//   Configuration returns to 24 bpp, RGB555, 256 palette entries. Palette
//   contents are undefined until written; there is no clearing pass.
// Backpressure:
//   While out_chan.ready is low the result register holds; one more request
//   waits in the read stage, after which in_chan.ready drops.
module bmp_pixel_to_rgba_converter #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  bpr_in_if.sink    in_chan,
  bpr_out_if.source out_chan,
  bpr_cfg_if.sink   cfg_chan
);
  import bpr_pkg::*;

  localparam int AW = $clog2(PALETTE_DEPTH);
  localparam logic [PAL_COUNT_W-1:0] DEPTH_LIM = PAL_COUNT_W'(PALETTE_DEPTH);

  cfg_t      cfg_r;
  logic      s1_valid_r;
  conv_req_t s1_req_r;
  conv_req_t s1_req_nxt;
  logic      s1_take;
  logic      in_accept;
  logic      conv_accept;
  logic      pal_we;
  logic [INDEX_W-1:0]     pix_idx;
  logic [PAL_COUNT_W-1:0] pix_idx_ext;
  logic [PAL_COUNT_W-1:0] wr_idx_ext;
  logic [PAL_COUNT_W-1:0] cnt_sat;
  logic [COLOR_W-1:0]     pal_word;

  // configuration
  assign cfg_chan.ready = 1'b1;
  assign cnt_sat = (cfg_chan.data > PAL_COUNT_MAX) ? PAL_COUNT_MAX : cfg_chan.data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bpp       <= BPP_RESET;
      cfg_r.bitfields <= 1'b0;
      cfg_r.pal_count <= PAL_COUNT_MAX;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        CFG_BPP:       cfg_r.bpp       <= cfg_chan.data[BPP_W-1:0];
        CFG_BITFIELDS: cfg_r.bitfields <= cfg_chan.data[0];
        CFG_PAL_COUNT: cfg_r.pal_count <= cnt_sat;
        default: ;
      endcase
    end
  end

  // request stage: palette write or palette read
  assign in_chan.ready = !s1_valid_r || s1_take;
  assign in_accept     = in_chan.valid && in_chan.ready;
  assign conv_accept   = in_accept && (in_chan.req_type == REQ_CONVERT);

  assign pix_idx     = in_chan.raw_pixel[INDEX_W-1:0];
  assign pix_idx_ext = PAL_COUNT_W'(pix_idx);
  assign wr_idx_ext  = PAL_COUNT_W'(in_chan.palette_index);
  assign pal_we      = in_accept && (in_chan.req_type == REQ_PAL_WRITE)
                       && (wr_idx_ext < DEPTH_LIM);

  assign s1_req_nxt.pixel   = in_chan.raw_pixel;
  assign s1_req_nxt.pal_hit = (pix_idx_ext < cfg_r.pal_count) && (pix_idx_ext < DEPTH_LIM);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= conv_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (conv_accept) begin
      s1_req_r <= s1_req_nxt;
    end
  end

  bpr_palette_ram #(
    .DEPTH (PALETTE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (pal_we),
    .waddr (in_chan.palette_index[AW-1:0]),
    .wdata (in_chan.palette_color),
    .re    (conv_accept),
    .raddr (pix_idx[AW-1:0]),
    .rdata (pal_word)
  );

  bpr_convert u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .req_valid (s1_valid_r),
    .req       (s1_req_r),
    .pal_word  (pal_word),
    .req_take  (s1_take),
    .out_chan  (out_chan)
  );

endmodule

[sv/bpr_palette_ram.sv]
// Palette memory: one write port, one read port with registered read data.
module bpr_palette_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          waddr,
  input  logic [bpr_pkg::COLOR_W-1:0] wdata,
  input  logic                   re,
  input  logic [AW-1:0]          raddr,
  output logic [bpr_pkg::COLOR_W-1:0] rdata
);
  import bpr_pkg::*;

  logic [COLOR_W-1:0] mem_r [DEPTH];
  logic [COLOR_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/bpr_convert.sv]
// Pixel format expansion and RGBA output register.
module bpr_convert (
  input  logic                     clk,
  input  logic                     rst_n,
  input  bpr_pkg::cfg_t            cfg,
  input  logic                     req_valid,
  input  bpr_pkg::conv_req_t       req,
  input  logic [bpr_pkg::COLOR_W-1:0] pal_word,
  output logic                     req_take,
  bpr_out_if.source                out_chan
);
  import bpr_pkg::*;

  logic              out_valid_r;
  logic [CHAN_W-1:0] red_r, green_r, blue_r, alpha_r;
  logic [CHAN_W-1:0] red_nxt, green_nxt, blue_nxt, alpha_nxt;
  logic [15:0]       p16;

  assign p16      = req.pixel[15:0];
  assign req_take = req_valid && (!out_valid_r || out_chan.ready);

  always_comb begin
    alpha_nxt = ALPHA_OPAQUE;
    unique case (cfg.bpp)
      BPP_16: begin
        if (cfg.bitfields) begin
          red_nxt   = expand5(p16[15:11]);
          green_nxt = expand6(p16[10:5]);
        end else begin
          // top bit unused in 555
          red_nxt   = expand5(p16[14:10]);
          green_nxt = expand5(p16[9:5]);
        end
        blue_nxt = expand5(p16[4:0]);
      end
      BPP_24: begin
        blue_nxt  = req.pixel[7:0];
        green_nxt = req.pixel[15:8];
        red_nxt   = req.pixel[23:16];
      end
      BPP_32: begin
        blue_nxt  = req.pixel[7:0];
        green_nxt = req.pixel[15:8];
        red_nxt   = req.pixel[23:16];
        alpha_nxt = req.pixel[31:24];
      end
      BPP_8: begin
        if (req.pal_hit) begin
          blue_nxt  = pal_word[7:0];
          green_nxt = pal_word[15:8];
          red_nxt   = pal_word[23:16];
        end else begin
          blue_nxt  = '0;
          green_nxt = '0;
          red_nxt   = '0;
        end
      end
      default: begin
        blue_nxt  = GREY_LEVEL;
        green_nxt = GREY_LEVEL;
        red_nxt   = GREY_LEVEL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (req_take) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      alpha_r <= alpha_nxt;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.red   = red_r;
  assign out_chan.green = green_r;
  assign out_chan.blue  = blue_r;
  assign out_chan.alpha = alpha_r;

endmodule

[sv/bpr_checker.sv]
// Port-level checks for the converter and their bind to the top level.
module bpr_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         in_req_type,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [bpr_pkg::CHAN_W-1:0]   out_red,
  input logic [bpr_pkg::CHAN_W-1:0]   out_green,
  input logic [bpr_pkg::CHAN_W-1:0]   out_blue,
  input logic [bpr_pkg::CHAN_W-1:0]   out_alpha
);
  import bpr_pkg::*;

  logic conv_req;
  assign conv_req = in_valid && in_ready && (in_req_type == REQ_CONVERT);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable({out_red, out_green, out_blue, out_alpha}))
    else $error("result changed while stalled");

  // a fresh result traces back to a conversion request that passed the read stage
  a_rise_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(conv_req, 2))
    else $error("result without a conversion request");

  // empty output register never holds off requests
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("request blocked with empty output");

endmodule

bind bmp_pixel_to_rgba_converter bpr_checker u_bpr_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .in_req_type (in_chan.req_type),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_red     (out_chan.red),
  .out_green   (out_chan.green),
  .out_blue    (out_chan.blue),
  .out_alpha   (out_chan.alpha)
);

[tb/bpr_rgba_check.sv]
// Watches the pixel converter channels, predicts each RGBA result and compares it.
module bpr_rgba_check #(
  parameter int PAL_DEPTH = 256
) (
  input  logic clk,
  input  logic rst_n,
  bpr_in_if    in_mon,
  bpr_out_if   out_mon,
  bpr_cfg_if   cfg_mon,
  output int   fail_count,
  output int   awaiting,
  output int   checked
);
  import bpr_pkg::*;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } rgba_t;

  logic [BPP_W-1:0]       depth;
  logic                   rgb565;
  logic [PAL_COUNT_W-1:0] entries;
  logic [COLOR_W-1:0]     palette [PAL_DEPTH];
  rgba_t                  pixels_due [$];
  int                     fails = 0;
  int                     results = 0;

  function automatic logic [CHAN_W-1:0] scale_up(input int unsigned v,
                                                 input int unsigned vmax);
    return CHAN_W'((v * 255) / vmax);
  endfunction

  function automatic rgba_t rgba_of(input logic [PIXEL_W-1:0] px);
    rgba_t c;
    c.red   = GREY_LEVEL;
    c.green = GREY_LEVEL;
    c.blue  = GREY_LEVEL;
    c.alpha = ALPHA_OPAQUE;
    case (depth)
      BPP_16: begin
        // in 555 mode bit 15 plays no part
        if (rgb565) begin
          c.red   = scale_up(px[15:11], 31);
          c.green = scale_up(px[10:5], 63);
        end else begin
          c.red   = scale_up(px[14:10], 31);
          c.green = scale_up(px[9:5], 31);
        end
        c.blue = scale_up(px[4:0], 31);
      end
      BPP_24: {c.red, c.green, c.blue} = px[23:0];
      BPP_32: {c.alpha, c.red, c.green, c.blue} = px;
      BPP_8: begin
        if (px[7:0] < entries && px[7:0] < PAL_DEPTH)
          {c.red, c.green, c.blue} = palette[px[7:0]];
        else
          {c.red, c.green, c.blue} = '0;
      end
      default: ;
    endcase
    return c;
  endfunction

  task automatic check_field(input string name, input logic [CHAN_W-1:0] want,
                             input logic [CHAN_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %02h, got %02h", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    rgba_t want;
    rgba_t got;
    if (!rst_n) begin
      depth   = BPP_RESET;
      rgb565  = 1'b0;
      entries = PAL_COUNT_MAX;
      pixels_due.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_BPP:       depth  = cfg_mon.data[BPP_W-1:0];
          CFG_BITFIELDS: rgb565 = cfg_mon.data[0];
          CFG_PAL_COUNT: entries = (cfg_mon.data > PAL_COUNT_MAX) ? PAL_COUNT_MAX
                                                                   : cfg_mon.data;
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.red, out_mon.green, out_mon.blue, out_mon.alpha};
        results++;
        if (pixels_due.size() == 0) begin
          $display("%0t: result expected none, got rgba %08h", $time, got);
          fails++;
        end else begin
          want = pixels_due.pop_front();
          check_field("red", want.red, got.red);
          check_field("green", want.green, got.green);
          check_field("blue", want.blue, got.blue);
          check_field("alpha", want.alpha, got.alpha);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.req_type == REQ_PAL_WRITE) begin
          if (in_mon.palette_index < PAL_DEPTH)
            palette[in_mon.palette_index] = in_mon.palette_color;
        end else begin
          pixels_due.insert(pixels_due.size(), rgba_of(in_mon.raw_pixel));
        end
      end
    end
    fail_count <= fails;
    awaiting   <= pixels_due.size();
    checked    <= results;
  end

endmodule

[tb/bmp_pixel_to_rgba_converter_tb.sv]
// Stimulus and verdict for the bitmap pixel to RGBA8888 converter.
module bmp_pixel_to_rgba_converter_tb;
  import bpr_pkg::*;

  localparam int PAL_DEPTH   = 256;
  localparam int TOTAL_ITEMS = 650;

  logic clk = 1'b0;
  logic rst_n;

  bpr_in_if  in_chan ();
  bpr_out_if out_chan ();
  bpr_cfg_if cfg_chan ();

  int  fail_count;
  int  awaiting;
  int  checked;
  bit  send_idle = 1'b0;
  bit  recv_idle = 1'b0;
  int  stall_left = 0;
  bit  written [PAL_DEPTH];
  int  conversions = 0;
  int  pal_writes = 0;
  int  settings = 0;
  logic [BPP_W-1:0] cur_depth = BPP_RESET;
  int  cur_entries = PAL_DEPTH;

  always #4 clk = ~clk;

  bmp_pixel_to_rgba_converter #(.PALETTE_DEPTH(PAL_DEPTH)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  bpr_rgba_check #(.PAL_DEPTH(PAL_DEPTH)) rgba_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .cfg_mon    (cfg_chan),
    .fail_count (fail_count),
    .awaiting   (awaiting),
    .checked    (checked)
  );

  // random result side back-pressure bursts, started only while recv_idle is set
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_chan.ready <= 1'b0;
    end else if (recv_idle && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 9);
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  // valid stays high between back-to-back requests unless send_idle inserts a random gap
  task automatic send(input logic rt, input logic [PIXEL_W-1:0] px,
                      input logic [INDEX_W-1:0] idx, input logic [COLOR_W-1:0] col);
    if (send_idle && $urandom_range(0, 5) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.req_type      <= rt;
    in_chan.raw_pixel     <= px;
    in_chan.palette_index <= idx;
    in_chan.palette_color <= col;
    do @(posedge clk); while (!in_chan.ready);
    if (rt == REQ_PAL_WRITE) begin
      written[idx] = 1'b1;
      pal_writes++;
    end else begin
      conversions++;
    end
  endtask

  task automatic convert(input logic [PIXEL_W-1:0] px);
    send(REQ_CONVERT, px, INDEX_W'($urandom), COLOR_W'($urandom));
  endtask

  task automatic pal_write(input logic [INDEX_W-1:0] idx, input logic [COLOR_W-1:0] col);
    send(REQ_PAL_WRITE, $urandom, idx, col);
  endtask

  // index read with random upper bytes; an unwritten live entry is written first
  task automatic palette_read(input logic [INDEX_W-1:0] idx);
    logic [PIXEL_W-1:0] px;
    px = $urandom;
    px[7:0] = idx;
    if (idx < cur_entries && !written[idx])
      pal_write(idx, COLOR_W'($urandom));
    convert(px);
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    // palette writes produce no result; give the pipe time to settle
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= val;
    do @(posedge clk); while (!cfg_chan.ready);
  endtask

  task automatic set_config(input logic [BPP_W-1:0] bpp, input logic bf,
                            input logic [PAL_COUNT_W-1:0] cnt);
    drain();
    write_reg(CFG_BPP, CFG_DATA_W'(bpp));
    write_reg(CFG_BITFIELDS, CFG_DATA_W'(bf));
    write_reg(CFG_PAL_COUNT, cnt);
    cfg_chan.valid <= 1'b0;
    cur_depth   = bpp;
    cur_entries = (cnt > PAL_DEPTH) ? PAL_DEPTH : cnt;
    settings++;
  endtask

  initial begin
    logic [BPP_W-1:0]       bpp;
    logic [PAL_COUNT_W-1:0] cnt;
    logic [PIXEL_W-1:0]     px;
    int                     sent;
    rst_n                 = 1'b0;
    in_chan.valid         = 1'b0;
    in_chan.req_type      = REQ_CONVERT;
    in_chan.raw_pixel     = '0;
    in_chan.palette_index = '0;
    in_chan.palette_color = '0;
    cfg_chan.valid        = 1'b0;
    cfg_chan.index        = CFG_BPP;
    cfg_chan.data         = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset setting: 24-bit BGR
    convert(32'h0000_0000);
    convert(32'hFFA5_C3E1);
    pal_write(8'd0, 24'hFFFFFF);
    pal_write(8'd255, 24'h123456);
    pal_write(8'd1, 24'h000000);
    pal_write(8'd170, 24'hAAAAAA);

    set_config(BPP_8, 1'b0, 9'd256);
    palette_read(8'd0);
    palette_read(8'd255);
    palette_read(8'd170);
    pal_write(8'd7, 24'hC0FFEE);
    palette_read(8'd7);           // read right behind its write

    set_config(BPP_8, 1'b0, 9'd2);
    palette_read(8'd1);
    palette_read(8'd2);           // first index past the count
    set_config(BPP_8, 1'b1, 9'd0);
    palette_read(8'd0);
    set_config(BPP_8, 1'b0, 9'd511);  // saturates to the full palette
    palette_read(8'd255);

    set_config(BPP_16, 1'b0, 9'd256);
    convert(32'h0000_7FFF);
    convert(32'h0000_8000);       // top bit ignored in 555
    convert(32'hFFFF_5295);
    set_config(BPP_16, 1'b1, 9'd256);
    convert(32'h0000_FFFF);
    convert(32'h0000_F81F);

    set_config(BPP_32, 1'b0, 9'd256);
    convert(32'hFFFF_FFFF);
    convert(32'h8040_2010);

    set_config(6'd0, 1'b0, 9'd256);
    convert($urandom);
    set_config(6'd63, 1'b1, 9'd256);
    convert($urandom);

    // random settings; the tail of the run has no idling on either side
    while (conversions + pal_writes < TOTAL_ITEMS) begin
      sent = conversions + pal_writes;
      send_idle <= (sent < TOTAL_ITEMS - 120) && $urandom_range(0, 2) != 0;
      recv_idle <= (sent < TOTAL_ITEMS - 120) && $urandom_range(0, 2) != 0;
      case ($urandom_range(0, 9))
        0, 1, 2: bpp = BPP_8;
        3, 4:    bpp = BPP_16;
        5:       bpp = BPP_24;
        6:       bpp = BPP_32;
        default: bpp = BPP_W'($urandom);
      endcase
      case ($urandom_range(0, 5))
        0:       cnt = PAL_COUNT_MAX;
        1:       cnt = 9'd511;
        2:       cnt = 9'd0;
        3:       cnt = 9'($urandom_range(1, 255));
        default: cnt = 9'($urandom_range(0, 511));
      endcase
      set_config(bpp, 1'($urandom), cnt);
      repeat ($urandom_range(15, 50)) begin
        if (cur_depth == BPP_8) begin
          if ($urandom_range(0, 4) == 0)
            pal_write(INDEX_W'($urandom), COLOR_W'($urandom));
          else if (cur_entries < PAL_DEPTH && $urandom_range(0, 3) == 0)
            palette_read(INDEX_W'($urandom_range(cur_entries, PAL_DEPTH - 1)));
          else
            palette_read(INDEX_W'($urandom));
        end else if ($urandom_range(0, 9) == 0) begin
          pal_write(INDEX_W'($urandom), COLOR_W'($urandom));
        end else begin
          case ($urandom_range(0, 15))
            0:       px = '0;
            1:       px = '1;
            default: px = $urandom;
          endcase
          convert(px);
        end
      end
    end

    drain();
    repeat (4) @(posedge clk);
    $display("Sent %0d pixel conversions and %0d palette writes over %0d register settings.",
             conversions, pal_writes, settings);
    $display("Compared %0d RGBA results, %0d field errors.", checked, fail_count);
    if (fail_count == 0 && awaiting == 0)
      $display("bmp_pixel_to_rgba_converter: match");
    else
      $display("bmp_pixel_to_rgba_converter: mismatch");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d results outstanding.", awaiting);
    $display("bmp_pixel_to_rgba_converter: mismatch");
    $finish;
  end

endmodule

[files.f]
sv/bpr_pkg.sv
sv/bpr_channels.sv
sv/bpr_palette_ram.sv
sv/bpr_convert.sv
sv/bmp_pixel_to_rgba_converter.sv
sv/bpr_checker.sv
tb/bpr_rgba_check.sv
tb/bmp_pixel_to_rgba_converter_tb.sv
